// ----- design/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int MAX_CODE_LEN = 16;
	localparam int CODE_W       = 16;
	localparam int LEN_W        = 5;
	localparam int TBL_AW       = $clog2(TABLE_DEPTH);
	localparam int LEN_LIMIT    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
	localparam int PEND_W       = 7;
	localparam int ACC_W        = PEND_W + CODE_W;
	localparam int TOT_W        = $clog2(ACC_W + 1);
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_ENCODE = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_pad_count;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} tbl_entry_t;

	// up to two result items per input item
	typedef struct packed {
		logic [1:0] n;
		out_item_t  item0;
		out_item_t  item1;
	} pack_t;

endpackage

// ----- design/hcbp_code_table.sv -----
// Code table memory: load writes, encode reads; the read is registered.
module hcbp_code_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc_en,
	input  hcbp_pkg::in_item_t  item,
	output hcbp_pkg::tbl_entry_t entry
);
	import hcbp_pkg::*;

	tbl_entry_t             mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;
	tbl_entry_t             rd_q;
	logic                   rd_hit_q;

	logic                   in_table;
	logic [TBL_AW-1:0]      idx;
	logic [LEN_W-1:0]       wr_len;
	logic [CODE_W:0]        wr_mask;
	tbl_entry_t             wr_ent;

	assign in_table = ({1'b0, item.symbol} < 9'(TABLE_DEPTH));
	assign idx      = item.symbol[TBL_AW-1:0];

	// clamp length, keep only the low len bits of the code
	always_comb begin
		wr_len      = (item.code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : item.code_len;
		wr_mask     = ((CODE_W+1)'(1) << wr_len) - (CODE_W+1)'(1);
		wr_ent.len  = wr_len;
		wr_ent.code = item.code_bits & wr_mask[CODE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (acc_en && in_table && item.action == ACT_LOAD) begin
			mem[idx] <= wr_ent;
		end
		if (acc_en) begin
			rd_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else if (acc_en) begin
			if (in_table && item.action == ACT_LOAD) begin
				vld_q[idx] <= 1'b1;
			end
			rd_hit_q <= in_table && vld_q[idx];
		end
	end

	// unwritten entry or symbol outside the table: zero length
	assign entry = rd_hit_q ? rd_q : '0;

endmodule

// ----- design/hcbp_bit_packer.sv -----
// Bit packer: packs code bits into bytes; finish adds tail and pad count.
module hcbp_bit_packer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s1_valid,
	input  logic [1:0]           s1_action,
	input  hcbp_pkg::tbl_entry_t entry,
	output hcbp_pkg::pack_t      pk
);
	import hcbp_pkg::*;

	logic [PEND_W-1:0] pend_bits_q;
	logic [2:0]        pend_cnt_q;

	logic [ACC_W-1:0]  acc;
	logic [TOT_W-1:0]  total;
	logic [2:0]        rem_cnt;
	logic [PEND_W-1:0] rem_mask;
	logic [2:0]        pad;
	logic [7:0]        tail;
	logic              upd;
	logic [PEND_W-1:0] nxt_bits;
	logic [2:0]        nxt_cnt;

	always_comb begin
		acc      = (ACC_W'(pend_bits_q) << entry.len) | ACC_W'(entry.code);
		total    = TOT_W'(pend_cnt_q) + TOT_W'(entry.len);
		rem_cnt  = total[2:0];
		rem_mask = (PEND_W'(1) << rem_cnt) - PEND_W'(1);
		pad      = 3'd0 - pend_cnt_q;
		tail     = 8'(pend_bits_q) << pad;

		pk       = '0;
		upd      = 1'b0;
		nxt_bits = pend_bits_q;
		nxt_cnt  = pend_cnt_q;

		if (s1_valid) begin
			case (s1_action)
				ACT_ENCODE: begin
					upd                = 1'b1;
					pk.item0.out_byte  = 8'(acc >> (total - TOT_W'(8)));
					pk.item1.out_byte  = 8'(acc >> (total - TOT_W'(16)));
					if (total >= TOT_W'(16)) begin
						pk.n = 2'd2;
					end else if (total >= TOT_W'(8)) begin
						pk.n = 2'd1;
					end
					nxt_cnt  = rem_cnt;
					nxt_bits = PEND_W'(acc) & rem_mask;
				end
				ACT_FINISH: begin
					upd      = 1'b1;
					nxt_cnt  = '0;
					nxt_bits = '0;
					if (pend_cnt_q != 3'd0) begin
						pk.n                  = 2'd2;
						pk.item0.out_byte     = tail;
						pk.item1.out_byte     = 8'(pad);
						pk.item1.is_pad_count = 1'b1;
						pk.item1.last         = 1'b1;
					end else begin
						pk.n                  = 2'd1;
						pk.item0.out_byte     = 8'(pad);
						pk.item0.is_pad_count = 1'b1;
						pk.item0.last         = 1'b1;
					end
				end
				default: begin
					upd = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (upd) begin
			pend_bits_q <= nxt_bits;
			pend_cnt_q  <= nxt_cnt;
		end
	end

endmodule

// ----- design/hcbp_out_fifo.sv -----
// Output queue: up to two items in a cycle, one out unless stalled.
module hcbp_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hcbp_pkg::pack_t            pk,
	output logic                       byte_valid,
	input  logic                       byte_stall,
	output hcbp_pkg::out_item_t        byte_item,
	output logic [hcbp_pkg::FIFO_CW-1:0] count
);
	import hcbp_pkg::*;

	out_item_t          buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;

	assign byte_valid = (cnt_q != '0);
	assign byte_item  = buf_q[rd_ptr_q];
	assign count      = cnt_q;
	assign pop        = byte_valid && !byte_stall;

	always_ff @(posedge clk) begin
		if (pk.n != 2'd0) begin
			buf_q[wr_ptr_q] <= pk.item0;
		end
		if (pk.n == 2'd2) begin
			buf_q[wr_ptr_q + FIFO_AW'(1)] <= pk.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(pk.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + FIFO_CW'(pk.n) - FIFO_CW'(pop);
		end
	end

endmodule

// ----- design/huffman_code_bit_packer.sv -----
// Top level of the Huffman code bit packer: table, packer and output queue.
//
//  channel | dir | handshake              | item
//  --------+-----+------------------------+-----------------------------------------
//  sym     | in  | sym_valid / sym_stall  | action, symbol, code_bits, code_len
//  byte    | out | byte_valid / byte_stall| out_byte, is_pad_count, last
//
// One item is taken per cycle while sym_stall is low. An accepted item reads
// or writes the code table at the accept edge; the table read is registered
// and the packer drops its 0..2 result items into an 8-entry queue at the
// next edge, and each result reaches the byte port once the items ahead of it
// have left. The byte port hands out one item a cycle while byte_stall is low,
// so the queue drain rate sets the pace when items make two bytes. sym_stall
// rises when the queue could not hold two more items for the item in flight
// plus two for a new one. Reset clears the table valid bits, the pending bits
// and the queue at once; there is no clearing pass.
module huffman_code_bit_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sym_valid,
	output logic                sym_stall,
	input  hcbp_pkg::in_item_t  sym_item,
	output logic                byte_valid,
	input  logic                byte_stall,
	output hcbp_pkg::out_item_t byte_item
);
	import hcbp_pkg::*;

	logic               acc_en;
	logic               s1_valid_q;
	logic [1:0]         s1_action_q;
	tbl_entry_t         entry;
	pack_t              pk;
	logic [FIFO_CW-1:0] fifo_cnt;
	logic [FIFO_CW:0]   need;

	assign acc_en = sym_valid && !sym_stall;

	// worst case: item in flight gives two, the new one two more
	assign need      = (FIFO_CW+1)'(fifo_cnt) + (s1_valid_q ? (FIFO_CW+1)'(2) : '0);
	assign sym_stall = need > (FIFO_CW+1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= acc_en;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			s1_action_q <= sym_item.action;
		end
	end

	hcbp_code_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.acc_en (acc_en),
		.item   (sym_item),
		.entry  (entry)
	);

	hcbp_bit_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid_q),
		.s1_action (s1_action_q),
		.entry     (entry),
		.pk        (pk)
	);

	hcbp_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.pk         (pk),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.count      (fifo_cnt)
	);

`ifndef SYNTHESIS
	// queue never overflows
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		(FIFO_CW+1)'(fifo_cnt) + (FIFO_CW+1)'(pk.n) <= (FIFO_CW+1)'(FIFO_DEPTH))
		else $error("output queue overflow");

	// a finish always closes the stream with a last item
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_action_q == ACT_FINISH) |->
		((pk.n == 2'd1 && pk.item0.last) || (pk.n == 2'd2 && pk.item1.last)))
		else $error("finish without last item");

	// a load produces no output
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_en && sym_item.action == ACT_LOAD) |=> (pk.n == 2'd0))
		else $error("load produced output");
`endif

endmodule

// ----- tb/sv/huffman_code_bit_packer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Huffman code bit packer: predicts packed bytes, checks the byte port.
module huffman_code_bit_packer_tb;
	import hcbp_pkg::*;

	// the one action code that the package leaves unnamed; the block ignores it
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// cycles the receiver refuses bytes for during each pressure window
	localparam int LONG_HOLD_CYCLES = 400;

	// width of one input item, for junk payloads
	localparam int IN_W = $bits(in_item_t);

	// Scoreboard: own copy of the code table and the partial byte, plus the
	// bytes still due on the output port, oldest first.
	class byte_stream_board;
		logic [CODE_W-1:0] code_of [TABLE_DEPTH];
		logic [LEN_W-1:0]  len_of  [TABLE_DEPTH];
		logic [PEND_W-1:0] held_bits;
		int unsigned       held_count;
		out_item_t         due_bytes[$];
		int unsigned       errors;
		int unsigned       bytes_seen;
		int unsigned       pad_seen;

		function new();
			foreach (code_of[i]) begin
				code_of[i] = '0;
				len_of[i]  = '0;
			end
			held_bits  = '0;
			held_count = 0;
			errors     = 0;
			bytes_seen = 0;
			pad_seen   = 0;
		endfunction

		// Accepted input item: update the table / packer, queue its bytes.
		// Returns 1 when the item had any effect.
		function bit note_item(in_item_t it);
			logic [ACC_W-1:0] acc;
			int unsigned      clen;
			int unsigned      total;
			int unsigned      n;
			out_item_t        ob;
			n = 0;
			case (it.action)
			ACT_LOAD: begin
				if (it.symbol >= TABLE_DEPTH)
					return 1'b0;
				clen = (it.code_len > LEN_LIMIT) ? LEN_LIMIT : it.code_len;
				len_of[it.symbol]  = LEN_W'(clen);
				code_of[it.symbol] = CODE_W'(it.code_bits & ((32'd1 << clen) - 32'd1));
				return 1'b1;
			end
			ACT_ENCODE: begin
				if (it.symbol >= TABLE_DEPTH || len_of[it.symbol] == 0)
					return 1'b0;
				clen  = len_of[it.symbol];
				acc   = ACC_W'(held_bits);
				acc   = (acc << clen) | ACC_W'(code_of[it.symbol]);
				total = held_count + clen;
				while (total >= 8 && n < 2) begin
					ob.out_byte     = 8'(acc >> (total - 8));
					ob.is_pad_count = 1'b0;
					ob.last         = 1'b0;
					due_bytes.push_back(ob);
					total -= 8;
					n++;
				end
				held_count = total % 8;
				held_bits  = PEND_W'(acc & ((32'd1 << held_count) - 32'd1));
				return 1'b1;
			end
			ACT_FINISH: begin
				if (held_count > 0) begin
					ob.out_byte     = {1'b0, held_bits} << (8 - held_count);
					ob.is_pad_count = 1'b0;
					ob.last         = 1'b0;
					due_bytes.push_back(ob);
				end
				ob.out_byte     = 8'((8 - held_count) % 8);
				ob.is_pad_count = 1'b1;
				ob.last         = 1'b1;
				due_bytes.push_back(ob);
				held_bits  = '0;
				held_count = 0;
				return 1'b1;
			end
			default:
				return 1'b0;
			endcase
		endfunction

		// Accepted output item against the oldest byte still due.
		function void check_byte(out_item_t got);
			out_item_t want;
			bytes_seen++;
			if (got.is_pad_count === 1'b1)
				pad_seen++;
			if (due_bytes.size() == 0) begin
				errors++;
				$display("%0t: byte %h pad %b last %b arrived, none expected",
					$time, got.out_byte, got.is_pad_count, got.last);
				return;
			end
			want = due_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				errors++;
				$display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
			end
			if (got.is_pad_count !== want.is_pad_count) begin
				errors++;
				$display("%0t: is_pad_count expected %b, got %b",
					$time, want.is_pad_count, got.is_pad_count);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last expected %b, got %b", $time, want.last, got.last);
			end
		endfunction
	endclass

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      sym_valid  = 1'b0;
	in_item_t  sym_item   = '0;
	logic      byte_stall = 1'b0;
	logic      sym_stall;
	logic      byte_valid;
	out_item_t byte_item;

	byte_stream_board board;

	// pacing state of the two sides; long_hold is shared by both
	bit tx_quiet  = 1'b0;	// sender offers back to back
	bit rx_quiet  = 1'b0;	// receiver never stalls outside pressure windows
	bit long_hold = 1'b0;	// receiver is in a pressure window; sender goes flat out

	// stimulus tallies for the summary
	int unsigned n_load, n_encode, n_finish, n_ignored, n_effective;

	huffman_code_bit_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym_item   (sym_item),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic in_item_t make_item(logic [1:0] act, logic [7:0] sym,
		logic [CODE_W-1:0] bits, logic [LEN_W-1:0] len);
		in_item_t it;
		it.action    = act;
		it.symbol    = sym;
		it.code_bits = bits;
		it.code_len  = len;
		return it;
	endfunction

	// Offer one item on the symbol port and wait until it is taken.
	// Called and returns at a falling edge. While idle, the payload carries
	// junk so that the block is seen to ignore it without valid.
	task automatic offer(input in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		gap = (tx_quiet || long_hold) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			sym_valid <= 1'b0;
			sym_item  <= IN_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		sym_valid <= 1'b1;
		sym_item  <= it;
		do
			@(posedge clk);
		while (sym_stall);
		if (board.note_item(it))
			n_effective++;
		case (it.action)
		ACT_LOAD:   n_load++;
		ACT_ENCODE: n_encode++;
		ACT_FINISH: n_finish++;
		default:    n_ignored++;
		endcase
		@(negedge clk);
	endtask

	// Symbols 0..31 form the working alphabet: most loads and encodes hit it,
	// so random streams mostly carry real codes. The rest of the range is
	// touched now and then, which also yields skipped (uncoded) symbols.
	function automatic logic [7:0] pick_symbol();
		return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 31)) : 8'($urandom);
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return LEN_W'($urandom_range(1, 16));
		else if (r < 95)
			return '0;
		else
			return LEN_W'($urandom_range(17, 31));	// clamped to 16 by the block
	endfunction

	// Byte receiver: stalls a random number of cycles before each byte, with
	// stretches of no stalling. Twice it refuses bytes for a long window so
	// that the output queue fills and the block pushes back on its input.
	initial begin : byte_sink
		int hold_left;
		int unsigned taken;
		hold_left = 0;
		taken     = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			byte_stall <= (hold_left > 0);
			@(posedge clk);
			if (byte_stall) begin
				hold_left--;
				if (hold_left == 0)
					long_hold = 1'b0;
			end else if (byte_valid) begin
				board.check_byte(byte_item);
				taken++;
				if (taken == 150 || taken == 800) begin
					hold_left = LONG_HOLD_CYCLES;
					long_hold = 1'b1;
				end else begin
					if ($urandom_range(0, 39) == 0)
						rx_quiet = !rx_quiet;
					hold_left = rx_quiet ? 0 : $urandom_range(0, 19);
				end
			end
		end
	end

	// Main sequence: reset, directed items, random items, drain, verdict.
	initial begin : stimulus
		int r;
		board       = new();
		n_load      = 0;
		n_encode    = 0;
		n_finish    = 0;
		n_ignored   = 0;
		n_effective = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// table is empty after reset: encode is skipped, finish gives only a zero pad count
		offer(make_item(ACT_ENCODE, 8'd0,   16'h0000, 5'd0));
		offer(make_item(ACT_FINISH, 8'd0,   16'h0000, 5'd0));
		// loads: overlong length clamps to 16, codes keep only their low bits
		offer(make_item(ACT_LOAD,   8'd0,   16'hFFFF, 5'd31));
		offer(make_item(ACT_LOAD,   8'd255, 16'h0000, 5'd1));
		offer(make_item(ACT_LOAD,   8'd1,   16'hFFFF, 5'd3));
		offer(make_item(ACT_LOAD,   8'd2,   16'hA5C3, 5'd8));
		offer(make_item(ACT_LOAD,   8'd3,   16'h5A3C, 5'd16));
		offer(make_item(ACT_LOAD,   8'd4,   16'h1234, 5'd0));
		// unused action with every payload bit set: no effect
		offer(make_item(ACT_UNUSED, 8'd255, 16'hFFFF, 5'd31));
		// 16 ones -> two full bytes at once
		offer(make_item(ACT_ENCODE, 8'd0,   16'h0000, 5'd0));
		offer(make_item(ACT_ENCODE, 8'd255, 16'hFFFF, 5'd31));
		offer(make_item(ACT_ENCODE, 8'd1,   16'h0000, 5'd0));
		// length-0 entry is skipped
		offer(make_item(ACT_ENCODE, 8'd4,   16'h0000, 5'd0));
		// 4 pending + 16 -> two bytes, 4 left
		offer(make_item(ACT_ENCODE, 8'd3,   16'h0000, 5'd0));
		offer(make_item(ACT_ENCODE, 8'd2,   16'h0000, 5'd0));
		// partial byte then pad count 4
		offer(make_item(ACT_FINISH, 8'd0,   16'h0000, 5'd0));
		offer(make_item(ACT_ENCODE, 8'd1,   16'h0000, 5'd0));
		offer(make_item(ACT_FINISH, 8'd77,  16'hFFFF, 5'd31));
		// table survives finish; reload with clamp, then land exactly on a byte boundary
		offer(make_item(ACT_LOAD,   8'd2,   16'h8001, 5'd17));
		offer(make_item(ACT_ENCODE, 8'd2,   16'h0000, 5'd0));
		offer(make_item(ACT_FINISH, 8'd0,   16'h0000, 5'd0));

		// --- random part ---
		// fill the working alphabet first so streams carry real codes
		for (int s = 0; s < 32; s++)
			offer(make_item(ACT_LOAD, 8'(s), CODE_W'($urandom), LEN_W'($urandom_range(1, 16))));

		while (n_load + n_encode + n_finish + n_ignored < 1550) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				offer(make_item(ACT_LOAD, pick_symbol(), CODE_W'($urandom), pick_length()));
			else if (r < 12)
				offer(make_item(ACT_FINISH, 8'($urandom), CODE_W'($urandom), LEN_W'($urandom)));
			else if (r < 14)
				offer(make_item(ACT_UNUSED, 8'($urandom), CODE_W'($urandom), LEN_W'($urandom)));
			else
				offer(make_item(ACT_ENCODE, pick_symbol(), CODE_W'($urandom), LEN_W'($urandom)));
		end
		// close the last stream so its tail is checked too
		offer(make_item(ACT_FINISH, 8'd0, 16'h0000, 5'd0));
		sym_valid <= 1'b0;

		// drain, then a few more cycles to catch any stray byte
		while (board.due_bytes.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Ran %0d items (%0d with an effect): %0d loads, %0d encodes, %0d finishes, %0d unused-action.",
			n_load + n_encode + n_finish + n_ignored, n_effective,
			n_load, n_encode, n_finish, n_ignored);
		$display("Checked %0d output bytes, %0d of them end-of-stream pad counts.",
			board.bytes_seen, board.pad_seen);
		if (board.errors == 0 && board.due_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, pressure windows included.
	initial begin : watchdog
		#5000000;
		$display("%0t: timeout, %0d bytes still due", $time, board.due_bytes.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- huffman_code_bit_packer.f -----
design/hcbp_pkg.sv
design/hcbp_code_table.sv
design/hcbp_bit_packer.sv
design/hcbp_out_fifo.sv
design/huffman_code_bit_packer.sv
tb/sv/huffman_code_bit_packer_tb.sv
